FILE: rtl/kplr_pkg.sv
// Shared types and constants for the keypad long-press and auto-repeat scanner.
package kplr_pkg;

    localparam int KEY_IDX_W = 4;
    localparam int LEVELS_W  = 16;
    localparam int TIMER_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // Highest key index that the 4-bit count and 16-bit level word can reach.
    localparam int KEY_IDX_MAX = 15;

    // Key phase codes.
    localparam logic [1:0] PH_UP   = 2'd0;
    localparam logic [1:0] PH_DOWN = 2'd1;
    localparam logic [1:0] PH_LONG = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_KEYS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MASK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PRESS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TICKS = 3'd4;

    // Configuration reset values.
    localparam logic [KEY_IDX_W-1:0] RST_NUM_KEYS     = 4'd7;
    localparam logic [LEVELS_W-1:0]  RST_ACTIVE_MASK  = 16'd0;
    localparam logic                 RST_REPORT_PRESS = 1'b0;
    localparam logic [TIMER_W-1:0]   RST_LONG_TICKS   = 16'd100;
    localparam logic [TIMER_W-1:0]   RST_REPEAT_TICKS = 16'd20;

    localparam logic [TIMER_W-1:0]   TIMER_MAX = {TIMER_W{1'b1}};

    typedef struct packed {
        logic [KEY_IDX_W-1:0] num_keys;
        logic [LEVELS_W-1:0]  active_level_mask;
        logic                 report_on_press;
        logic [TIMER_W-1:0]   long_ticks;
        logic [TIMER_W-1:0]   repeat_ticks;
    } cfg_t;

    typedef struct packed {
        logic                 hit;
        logic [KEY_IDX_W-1:0] key_index;
        logic                 long_event;
    } key_event_t;

endpackage

FILE: rtl/key_press_long_repeat_scanner_unit.sv
// Top level of the keypad scanner with long-press and auto-repeat events.
//
//   Channel   Direction  Handshake           Payload
//   -------   ---------  ------------------  ------------------------------------
//   in        input      in_valid/in_stall   key_levels (16 bits)
//   out       output     out_valid/out_stall key_index (4 bits), long_event (1 bit)
//   cfg       input      cfg_write           cfg_index (3 bits), cfg_data (16 bits)
//
// An item is taken into the input register, scanned against the stored key
// phases and hold timer, and its event (if any) lands in the output register.
// One item per cycle is sustained; the only limit is the single-entry output
// register, which holds the input register while a result is stalled.
// Items that cause no event still update the key phases and timer and leave no result.
// rst_n clears all key phases to up, the hold timer to zero, both valid flags, and
// loads the configuration registers with their defaults.
module key_press_long_repeat_scanner_unit
    import kplr_pkg::*;
#(
    parameter int MAX_KEYS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [LEVELS_W-1:0]   key_levels,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KEY_IDX_W-1:0]  key_index,
    output logic                  long_event
);

    // Keys are visited from index 1 up to the smaller of MAX_KEYS - 1 and the
    // highest index the count register can hold; no phase is kept for others.
    localparam int SCAN_KEYS = (MAX_KEYS - 1 < KEY_IDX_MAX) ? MAX_KEYS - 1 : KEY_IDX_MAX;

    cfg_t                    cfg;

    logic                    in_valid_reg;
    logic [LEVELS_W-1:0]     levels_reg;
    logic [SCAN_KEYS:1][1:0] phase_reg;
    logic [SCAN_KEYS:1][1:0] phase_next;
    logic [TIMER_W-1:0]      timer_reg;
    logic [TIMER_W-1:0]      timer_next;
    key_event_t              key_event;

    logic                    out_valid_reg;
    logic [KEY_IDX_W-1:0]    key_index_reg;
    logic                    long_event_reg;

    logic                    proceed;
    logic                    in_accept;

    kplr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kplr_scan #(
        .SCAN_KEYS (SCAN_KEYS)
    ) u_scan (
        .cfg             (cfg),
        .key_levels      (levels_reg),
        .phase           (phase_reg),
        .hold_timer      (timer_reg),
        .phase_next      (phase_next),
        .hold_timer_next (timer_next),
        .key_event       (key_event)
    );

    // The held item is scanned once the output register is free or is being
    // emptied in this cycle.
    assign proceed   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !proceed;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            timer_reg     <= '0;
        end
        else
        begin
            if (in_accept)
                in_valid_reg <= 1'b1;
            else if (proceed)
                in_valid_reg <= 1'b0;

            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (proceed && key_event.hit)
                out_valid_reg <= 1'b1;

            if (proceed)
            begin
                phase_reg <= phase_next;
                timer_reg <= timer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            levels_reg <= key_levels;
        if (proceed && key_event.hit)
        begin
            key_index_reg  <= key_event.key_index;
            long_event_reg <= key_event.long_event;
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_index  = key_index_reg;
    assign long_event = long_event_reg;

endmodule

FILE: rtl/kplr_cfg_regs.sv
// Configuration register bank of the keypad scanner.
module kplr_cfg_regs
    import kplr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_keys          <= RST_NUM_KEYS;
            cfg_reg.active_level_mask <= RST_ACTIVE_MASK;
            cfg_reg.report_on_press   <= RST_REPORT_PRESS;
            cfg_reg.long_ticks        <= RST_LONG_TICKS;
            cfg_reg.repeat_ticks      <= RST_REPEAT_TICKS;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_NUM_KEYS:     cfg_reg.num_keys          <= cfg_data[KEY_IDX_W-1:0];
                CFG_ACTIVE_MASK:  cfg_reg.active_level_mask <= cfg_data[LEVELS_W-1:0];
                CFG_REPORT_PRESS: cfg_reg.report_on_press   <= cfg_data[0];
                CFG_LONG_TICKS:   cfg_reg.long_ticks        <= cfg_data[TIMER_W-1:0];
                CFG_REPEAT_TICKS: cfg_reg.repeat_ticks      <= cfg_data[TIMER_W-1:0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/kplr_scan.sv
// Single-pass key scan: next key phases, next hold timer and the event of one tick.
module kplr_scan
    import kplr_pkg::*;
#(
    parameter int SCAN_KEYS = 15
)
(
    input  cfg_t                        cfg,
    input  logic [LEVELS_W-1:0]         key_levels,
    input  logic [SCAN_KEYS:1][1:0]     phase,
    input  logic [TIMER_W-1:0]          hold_timer,
    output logic [SCAN_KEYS:1][1:0]     phase_next,
    output logic [TIMER_W-1:0]          hold_timer_next,
    output key_event_t                  key_event
);

    logic hold_ge_long;
    logic hold_ge_repeat;
    logic long_is_zero;
    logic repeat_is_zero;

    assign hold_ge_long   = (hold_timer >= cfg.long_ticks);
    assign hold_ge_repeat = (hold_timer >= cfg.repeat_ticks);
    assign long_is_zero   = (cfg.long_ticks == '0);
    assign repeat_is_zero = (cfg.repeat_ticks == '0);

    // A released long key clears the timer for every key after it in the pass,
    // so the comparisons switch to their zero-timer form once that happened.
    always_comb
    begin
        logic cleared;
        logic done;
        logic visit;
        logic pressed;
        logic ge_long;
        logic ge_repeat;

        cleared    = 1'b0;
        done       = 1'b0;
        phase_next = phase;
        key_event  = '0;

        for (int i = 1; i <= SCAN_KEYS; i++)
        begin
            visit     = (cfg.num_keys >= KEY_IDX_W'(i)) && !done;
            pressed   = (key_levels[i] == cfg.active_level_mask[i]);
            ge_long   = cleared ? long_is_zero : hold_ge_long;
            ge_repeat = (cleared || !pressed) ? repeat_is_zero : hold_ge_repeat;

            if (visit)
            begin
                case (phase[i])
                    PH_UP:
                    begin
                        if (pressed)
                        begin
                            phase_next[i] = PH_DOWN;
                            if (cfg.report_on_press)
                            begin
                                done      = 1'b1;
                                key_event = '{hit: 1'b1, key_index: KEY_IDX_W'(i),
                                              long_event: 1'b0};
                            end
                        end
                    end
                    PH_DOWN:
                    begin
                        if (!pressed)
                        begin
                            phase_next[i] = PH_UP;
                            if (!cfg.report_on_press)
                            begin
                                done      = 1'b1;
                                key_event = '{hit: 1'b1, key_index: KEY_IDX_W'(i),
                                              long_event: 1'b0};
                            end
                        end
                        else if (ge_long)
                        begin
                            phase_next[i] = PH_LONG;
                            done          = 1'b1;
                            key_event     = '{hit: 1'b1, key_index: KEY_IDX_W'(i),
                                              long_event: 1'b1};
                        end
                    end
                    PH_LONG:
                    begin
                        if (!pressed)
                        begin
                            phase_next[i] = PH_UP;
                            cleared       = 1'b1;
                        end
                        if (ge_repeat)
                        begin
                            done      = 1'b1;
                            key_event = '{hit: 1'b1, key_index: KEY_IDX_W'(i),
                                          long_event: 1'b1};
                        end
                    end
                    default:
                    begin
                        phase_next[i] = PH_UP;
                    end
                endcase
            end
        end

        // An event clears the timer; otherwise it advances from zero or from
        // its old value and stops at full scale.
        if (key_event.hit)
            hold_timer_next = '0;
        else if (cleared)
            hold_timer_next = TIMER_W'(1);
        else if (hold_timer != TIMER_MAX)
            hold_timer_next = hold_timer + TIMER_W'(1);
        else
            hold_timer_next = hold_timer;
    end

endmodule

FILE: rtl/kplr_checker.sv
// Port-level assertions for the keypad scanner and their bind to the top level.
module kplr_checker
    import kplr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [KEY_IDX_W-1:0]  key_index,
    input logic                  long_event
);

    // Reset leaves no result pending and no input held back.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> (!out_valid && !in_stall))
        else $error("scanner not quiet during reset");

    // The input side only waits on a full output register that is itself stalled.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

    // Key index zero is never scanned, so it never names an event.
    a_index_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (key_index != '0))
        else $error("event reported for key index zero");

    // A stalled result stays offered with the same payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(key_index) && $stable(long_event)))
        else $error("stalled result changed or dropped");

endmodule

bind key_press_long_repeat_scanner_unit kplr_checker u_kplr_checker (.*);
